// ===== sv/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5_pkg
// Types, constants and round tables shared by the MD5 digest block.
// ----------------------------------------------------------------------------
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } md5_out_t;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       put_byte;   // write data byte at current position, count it
    logic       put_pad;    // write pad byte at current position
    logic       put_len;    // write bit length into words 14 and 15
    logic       load_round; // copy chaining words into round words
    logic       do_round;   // run one round at round index
    logic       fold;       // add round words into chaining words, clear block
    logic       emit;       // drive digest word
    logic [1:0] emit_sel;   // which chaining word
    logic       clear_all;  // return to start values
  } md5_cmd_t;

  typedef struct packed {
    logic       block_full; // current byte position is 63
    logic       pad_spill;  // pad position at or above 56
    logic       round_last; // round index is 63
  } md5_sts_t;

  function automatic logic [31:0] md5_sine(input logic [5:0] i);
    logic [31:0] t [64];
    t = '{32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
          32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
          32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
          32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
          32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
          32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
          32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
          32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
          32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
          32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
          32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
          32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
          32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
          32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
          32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
          32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return t[i];
  endfunction

  function automatic logic [4:0] md5_rot(input logic [5:0] i);
    logic [4:0] r [16];
    r = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
          5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
    return r[{i[5:4], i[1:0]}];
  endfunction

  // Message word index per round, modulo 16 by truncation
  function automatic logic [3:0] md5_widx(input logic [5:0] i);
    logic [7:0] p;
    case (i[5:4])
      2'd0:    p = {2'b00, i};
      2'd1:    p = 8'd1 + 8'd5 * {2'b00, i};
      2'd2:    p = 8'd5 + 8'd3 * {2'b00, i};
      default: p = 8'd7 * {2'b00, i};
    endcase
    return p[3:0];
  endfunction

endpackage

// ===== sv/md5_datapath.sv =====
// ----------------------------------------------------------------------------
// md5_datapath
// Message block, byte counter, chaining and round words, one round a cycle.
// ----------------------------------------------------------------------------
module md5_datapath import md5_pkg::*; #(
  parameter int LengthCounterBits = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  md5_cmd_t cmd_i,
  input  md5_in_t  in_i,
  output md5_sts_t sts_o,
  output logic     strobe_o,
  output md5_out_t out_o
);

  logic [31:0] blk_q [16];
  logic [63:0] cnt_q;
  logic [31:0] ch_q [4];
  logic [31:0] rw_q [4];
  logic [5:0]  rnd_q;
  logic        strobe_q;
  md5_out_t    out_q;

  logic [5:0]  pos;
  logic [31:0] f, sum, rot;
  logic [4:0]  sh;
  logic [63:0] bits;
  logic [63:0] mask;

  assign pos  = cnt_q[5:0];
  assign mask = {64{1'b1}} >> (64 - LengthCounterBits);
  assign bits = {cnt_q[60:0], 3'b000} & mask;

  always_comb begin
    case (rnd_q[5:4])
      2'd0:    f = (rw_q[1] & rw_q[2]) | (~rw_q[1] & rw_q[3]);
      2'd1:    f = (rw_q[1] & rw_q[3]) | (rw_q[2] & ~rw_q[3]);
      2'd2:    f = rw_q[1] ^ rw_q[2] ^ rw_q[3];
      default: f = rw_q[2] ^ (rw_q[1] | ~rw_q[3]);
    endcase
    sum = rw_q[0] + f + blk_q[md5_widx(rnd_q)] + md5_sine(rnd_q);
    sh  = md5_rot(rnd_q);
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  assign sts_o.block_full = (pos == 6'd63);
  assign sts_o.pad_spill  = (pos >= 6'd56);
  assign sts_o.round_last = (rnd_q == 6'd63);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) blk_q[i] <= '0;
      cnt_q <= '0;
      rnd_q <= '0;
      ch_q  <= '{InitA, InitB, InitC, InitD};
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit;
      if (cmd_i.put_byte) begin
        blk_q[pos[5:2]][pos[1:0]*8 +: 8] <= in_i.data_byte;
        cnt_q <= cnt_q + 64'd1;
      end
      if (cmd_i.put_pad) blk_q[pos[5:2]][pos[1:0]*8 +: 8] <= PadByte;
      if (cmd_i.put_len) begin
        blk_q[14] <= bits[31:0];
        blk_q[15] <= bits[63:32];
      end
      if (cmd_i.do_round) rnd_q <= rnd_q + 6'd1;
      if (cmd_i.fold) begin
        for (int i = 0; i < 4; i++) ch_q[i] <= ch_q[i] + rw_q[i];
        for (int i = 0; i < 16; i++) blk_q[i] <= '0;
      end
      if (cmd_i.clear_all) begin
        for (int i = 0; i < 16; i++) blk_q[i] <= '0;
        cnt_q <= '0;
        ch_q  <= '{InitA, InitB, InitC, InitD};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_round) rw_q <= ch_q;
    if (cmd_i.do_round) begin
      rw_q[0] <= rw_q[3];
      rw_q[3] <= rw_q[2];
      rw_q[2] <= rw_q[1];
      rw_q[1] <= rw_q[1] + rot;
    end
    if (cmd_i.emit) begin
      out_q.digest_word <= ch_q[cmd_i.emit_sel];
      out_q.digest_last <= (cmd_i.emit_sel == 2'd3);
    end
  end

  assign strobe_o = strobe_q;
  assign out_o    = out_q;

  a_round_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.do_round && sts_o.round_last) |=> (rnd_q == 6'd0))
    else $error("round index did not wrap");
  a_fold_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fold |=> (blk_q[0] == 32'd0))
    else $error("block not cleared after fold");
  a_clear_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_all |=> (ch_q[0] == InitA && cnt_q == 64'd0))
    else $error("state not restored");

endmodule

// ===== sv/md5_ctrl.sv =====
// ----------------------------------------------------------------------------
// md5_ctrl
// Sequencer: byte intake, compressions, padding and digest output.
// ----------------------------------------------------------------------------
module md5_ctrl import md5_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     final_i,
  input  md5_sts_t sts_i,
  output logic     busy_o,
  output md5_cmd_t cmd_o
);

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StLoad  = 8'b0000_0010,
    StRound = 8'b0000_0100,
    StFold  = 8'b0000_1000,
    StPad   = 8'b0001_0000,
    StLen   = 8'b0010_0000,
    StEmit  = 8'b0100_0000,
    StDone  = 8'b1000_0000
  } state_e;

  state_e     state_q, state_d;
  logic       fin_q, fin_d;   // message ends after current compression
  logic       lenp_q, lenp_d; // length block pending
  logic [1:0] sel_q, sel_d;
  logic       emit_pend_q;

  assign busy_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    lenp_d  = lenp_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.emit_sel = sel_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.put_byte = 1'b1;
          fin_d = final_i;
          if (sts_i.block_full) begin
            lenp_d  = 1'b0;
            state_d = StLoad;
          end else if (final_i) begin
            state_d = StPad;
          end
        end
      end
      StLoad: begin
        cmd_o.load_round = 1'b1;
        state_d = StRound;
      end
      StRound: begin
        cmd_o.do_round = 1'b1;
        if (sts_i.round_last) state_d = StFold;
      end
      StFold: begin
        cmd_o.fold = 1'b1;
        if (lenp_q) state_d = StLen;
        else if (fin_q) state_d = StPad;
        else state_d = StIdle;
      end
      StPad: begin
        cmd_o.put_pad = 1'b1;
        fin_d = 1'b0;
        if (sts_i.pad_spill) begin
          lenp_d  = 1'b1;
          state_d = StLoad;
        end else begin
          state_d = StLen;
        end
      end
      StLen: begin
        cmd_o.put_len = 1'b1;
        lenp_d = 1'b0;
        fin_d  = 1'b0;
        sel_d  = 2'd0;
        state_d = StLoad;
        // after this compression, emit
        lenp_d = 1'b0;
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        sel_d = sel_q + 2'd1;
        if (sel_q == 2'd3) state_d = StDone;
      end
      StDone: begin
        cmd_o.clear_all = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
    // route the length block's fold to emission
    if (state_q == StFold && !lenp_q && !fin_q && emit_pend_q) state_d = StEmit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fin_q   <= 1'b0;
      lenp_q  <= 1'b0;
      sel_q   <= 2'd0;
      emit_pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      lenp_q  <= lenp_d;
      sel_q   <= state_q == StLen ? 2'd0 : sel_d;
      if (state_q == StLen) emit_pend_q <= 1'b1;
      else if (state_q == StEmit) emit_pend_q <= 1'b0;
    end
  end

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !cmd_o.put_byte)
    else $error("byte written while busy");
  a_emit_four: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && sel_q == 2'd3) |=> (state_q == StDone))
    else $error("emit sequence broken");
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");

endmodule

// ===== sv/md5_message_digest_top.sv =====
// ----------------------------------------------------------------------------
// md5_message_digest_top
// MD5 digest of a byte stream, emitted as four chaining words.
// ----------------------------------------------------------------------------
// Input: a byte is transferred at a clock edge with start_i high and busy_o
// low; in_i.final_byte marks the last byte of a message.
// A byte that neither fills a block nor ends the message keeps busy_o low. A
// byte completing a 64-byte block starts a compression: load, 64 rounds of
// the single round unit, fold. The final byte pads, compresses once or twice
// and then drives four results on consecutive cycles, strobe_o high, words
// A, B, C, D, with digest_last on D. The receiver cannot stall; each result
// is valid for exactly one cycle. After D the state returns to the start
// values, busy_o drops. Asynchronous reset clears all but rw_q and out_q.
// ----------------------------------------------------------------------------
module md5_message_digest_top import md5_pkg::*; #(
  parameter int LENGTH_COUNTER_BITS = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  md5_in_t  in_i,
  output logic     busy_o,
  output logic     strobe_o,
  output md5_out_t out_o
);

  md5_cmd_t cmd;
  md5_sts_t sts;

  md5_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .final_i(in_i.final_byte),
    .sts_i  (sts),
    .busy_o (busy_o),
    .cmd_o  (cmd)
  );

  md5_datapath #(.LengthCounterBits(LENGTH_COUNTER_BITS)) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .in_i    (in_i),
    .sts_o   (sts),
    .strobe_o(strobe_o),
    .out_o   (out_o)
  );

endmodule
